// File: design/tdt_pkg.sv
// Shared types and constants for the tile deduplication table.
`default_nettype none
package tdt_pkg;

    // Table geometry.
    localparam int MAX_TILES = 1024;
    localparam int IDX_W     = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam int CNT_W     = $clog2(MAX_TILES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TILES);

    // Field widths fixed by the interface.
    localparam int PAT_W      = 64;
    localparam int PART_W     = 56;
    localparam int ROW_W      = 8;
    localparam int TILE_IDX_W = 12;
    localparam int UCNT_W     = 11;
    localparam int CMD_W      = 2;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 2;

    // Row commands.
    localparam logic [CMD_W-1:0] CMD_LEARN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MAP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Register indexes.
    localparam logic [APB_AW-1:0] REG_INDEX_OFFSET = 2'd0;
    localparam logic [TILE_IDX_W-1:0] OFFSET_RESET = 12'd65;

    typedef enum logic [1:0] {
        ST_MATCHED  = 2'd0,
        ST_INSERTED = 2'd1,
        ST_MISSING  = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic             launch;
        logic             clear;
        logic             learn;
        logic [PAT_W-1:0] pattern;
    } t_search_req;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] index;
        t_status          status;
        logic [CNT_W-1:0] count;
    } t_search_res;

endpackage
`default_nettype wire

// File: design/tdt_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module tdt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic                             i_re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: design/tdt_search.sv
// Sequential table search, insert and clear engine around the tile store.
`default_nettype none
module tdt_search
    import tdt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_search_req i_req,
    output logic             o_busy,
    output t_search_res      o_res
);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_ptr;
    logic             r_inflight;
    logic [IDX_W-1:0] r_cmp_idx;
    logic [PAT_W-1:0] r_pattern;
    logic             r_learn;
    logic             r_done;
    logic [IDX_W-1:0] r_res_idx;
    t_status          r_res_status;

    logic [PAT_W-1:0] rdata;
    logic             rd_en;
    logic             hit;
    logic             exhausted;
    logic             full;
    logic             wr_en;

    // One entry is read per cycle; its data is compared in the cycle after the read.
    assign rd_en     = (r_state == S_SCAN) && (r_ptr < r_count);
    assign hit       = (r_state == S_SCAN) && r_inflight && (rdata == r_pattern);
    assign exhausted = (r_state == S_SCAN) && !r_inflight && !rd_en;
    assign full      = (r_count >= MAX_CNT);
    assign wr_en     = exhausted && r_learn && !full;

    tdt_ram #(
        .WIDTH(PAT_W),
        .DEPTH(MAX_TILES)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(r_count[IDX_W-1:0]),
        .i_wdata(r_pattern),
        .i_re   (rd_en),
        .i_raddr(r_ptr[IDX_W-1:0]),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_inflight <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.clear) begin
                        r_count <= '0;
                    end
                    if (i_req.launch) begin
                        r_pattern  <= i_req.pattern;
                        r_learn    <= i_req.learn;
                        r_ptr      <= '0;
                        r_inflight <= 1'b0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        r_res_idx    <= r_cmp_idx;
                        r_res_status <= ST_MATCHED;
                        r_done       <= 1'b1;
                        r_inflight   <= 1'b0;
                        r_state      <= S_IDLE;
                    end else if (exhausted) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                        if (!r_learn) begin
                            r_res_idx    <= '0;
                            r_res_status <= ST_MISSING;
                        end else if (full) begin
                            r_res_idx    <= '0;
                            r_res_status <= ST_FULL;
                        end else begin
                            r_res_idx    <= r_count[IDX_W-1:0];
                            r_res_status <= ST_INSERTED;
                            r_count      <= r_count + CNT_W'(1);
                        end
                    end else begin
                        if (rd_en) begin
                            r_ptr <= r_ptr + CNT_W'(1);
                        end
                        r_inflight <= rd_en;
                        r_cmp_idx  <= r_ptr[IDX_W-1:0];
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_res.done   = r_done;
    assign o_res.index  = r_res_idx;
    assign o_res.status = r_res_status;
    assign o_res.count  = r_count;

endmodule
`default_nettype wire

// File: design/tile_dedup_table.sv
// Top level of the 8x8 one-bit tile deduplication table.
`default_nettype none
// A tile arrives as eight row beats on the command channel: a beat is taken at
// a rising edge where start is high and busy is low. Each beat carries a
// command and eight pixel bytes; a nonzero byte is a set pixel, and the row
// packs to one byte with pixel0 in the top bit. Rows one to seven are only
// shifted into a 56-bit assembly register, with busy staying low. The
// command of the eighth row picks learn or map and launches a search of the
// tile store, one entry per cycle through a single read port and a single
// 64-bit comparator, lowest index first.
// The eighth row keeps busy high while the search runs. The result beat
// follows in the cycle after busy drops. The result appears on o_tile_index,
// o_status and o_unique_count for exactly one cycle, marked by
// o_result_valid; the receiver cannot stall it. A learn miss appends the
// tile when there is room. A clear beat empties the table and drops a partly
// assembled tile; command three is ignored. Neither yields a result.
// The APB port holds index_offset; every word address selects it. It is added
// to a matched or inserted index. Reset clears the row position and the table
// count and sets the offset to 65. No clearing pass is needed: only entries
// below the count are ever read.
module tile_dedup_table
    import tdt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Command channel.
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [CMD_W-1:0]      i_command,
    input  wire logic [ROW_W-1:0]      i_pixel0,
    input  wire logic [ROW_W-1:0]      i_pixel1,
    input  wire logic [ROW_W-1:0]      i_pixel2,
    input  wire logic [ROW_W-1:0]      i_pixel3,
    input  wire logic [ROW_W-1:0]      i_pixel4,
    input  wire logic [ROW_W-1:0]      i_pixel5,
    input  wire logic [ROW_W-1:0]      i_pixel6,
    input  wire logic [ROW_W-1:0]      i_pixel7,
    // Result channel.
    output logic                       o_result_valid,
    output logic [TILE_IDX_W-1:0]      o_tile_index,
    output logic [1:0]                 o_status,
    output logic [UCNT_W-1:0]          o_unique_count,
    // Configuration port.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_AW-1:0]     paddr,
    input  wire logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]          prdata,
    output logic                       pready
);

    logic [TILE_IDX_W-1:0] r_offset;
    logic [2:0]            r_row_pos;
    logic [PART_W-1:0]     r_partial;

    logic                  accept;
    logic [ROW_W-1:0]      row;
    logic                  search_busy;
    t_search_req           req;
    t_search_res           res;

    assign accept = start && !busy;

    // A pixel is set when any bit of its byte is set.
    assign row = {|i_pixel0, |i_pixel1, |i_pixel2, |i_pixel3,
                  |i_pixel4, |i_pixel5, |i_pixel6, |i_pixel7};

    // The eighth row of a learn or map tile launches the search; a clear beat
    // resets the table count.
    always_comb begin
        req.launch  = 1'b0;
        req.clear   = 1'b0;
        req.learn   = (i_command == CMD_LEARN);
        req.pattern = {r_partial, row};
        if (accept) begin
            case (i_command)
                CMD_LEARN, CMD_MAP: req.launch = (r_row_pos == 3'd7);
                CMD_CLEAR:          req.clear  = 1'b1;
                default:            req.launch = 1'b0;
            endcase
        end
    end

    // Row assembly: earlier rows sit in the higher bytes of the pattern.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pos <= '0;
            r_partial <= '0;
        end else if (accept) begin
            case (i_command)
                CMD_LEARN, CMD_MAP: begin
                    if (r_row_pos == 3'd7) begin
                        r_row_pos <= '0;
                        r_partial <= '0;
                    end else begin
                        r_row_pos <= r_row_pos + 3'd1;
                        r_partial <= {r_partial[PART_W-ROW_W-1:0], row};
                    end
                end
                CMD_CLEAR: begin
                    r_row_pos <= '0;
                    r_partial <= '0;
                end
                default: begin
                    r_row_pos <= r_row_pos;
                end
            endcase
        end
    end

    tdt_search u_search (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req),
        .o_busy (search_busy),
        .o_res  (res)
    );

    assign busy = search_busy;

    // Result beat: the offset is added only to a matched or inserted index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= res.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.done) begin
            if (res.status == ST_MATCHED || res.status == ST_INSERTED) begin
                o_tile_index <= TILE_IDX_W'(res.index) + r_offset;
            end else begin
                o_tile_index <= '0;
            end
            o_status       <= res.status;
            o_unique_count <= UCNT_W'(res.count);
        end
    end

    // Configuration register. With a single register every word address
    // selects index_offset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= OFFSET_RESET;
        end else if (psel && penable && pwrite && pready) begin
            r_offset <= pwdata[TILE_IDX_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_INDEX_OFFSET || paddr != REG_INDEX_OFFSET)
                    ? APB_DW'(r_offset) : '0;

endmodule
`default_nettype wire
